>>> src/lsrb_pkg.sv
// Package: shared types, constants and tables for the lidar bin re-projector.
package lsrb_pkg;

    localparam int NUM_BINS     = 90;
    localparam int NUM_NODES    = 360;
    localparam int CORDIC_STEPS = 16;
    localparam int BIN_W        = 7;
    localparam int STEP_W       = 5;
    localparam int CW           = 40;   // CORDIC datapath width (signed)

    localparam logic [15:0] UNWRITTEN_MM = 16'd6000;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [6:0]  MAX_BEAM     = 7'd90;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_DETECT = 3'd1;
    localparam logic [2:0] REG_MIN    = 3'd2;
    localparam logic [2:0] REG_COUNT  = 3'd3;
    localparam logic [2:0] REG_MIRROR = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [8:0]  node_index;
        logic [15:0] raw_distance;
        logic [6:0]  bin_select;
    } req_word_t;

    typedef struct packed {
        logic [6:0]  bin_number;
        logic [15:0] bin_range_mm;
    } res_word_t;

    typedef struct packed {
        logic [13:0] center_offset_mm;
        logic [13:0] detect_range_mm;
        logic [13:0] min_dist_mm;
        logic [6:0]  angle_count;
        logic        mirror_mode;
    } cfg_t;

    // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
    function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [21:0] r;
        unique case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/lsrb_cordic.sv
// Shared CORDIC step unit: one micro-rotation per cycle, rotate or vector mode.
module lsrb_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                vector_mode,
    input  logic signed [lsrb_pkg::CW-1:0]      x_in,
    input  logic signed [lsrb_pkg::CW-1:0]      y_in,
    input  logic signed [lsrb_pkg::CW-1:0]      z_in,
    output logic                                done,
    output logic signed [lsrb_pkg::CW-1:0]      x_out,
    output logic signed [lsrb_pkg::CW-1:0]      z_out
);
    logic signed [lsrb_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic signed [lsrb_pkg::CW-1:0] x_next, y_next, z_next;
    logic [lsrb_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                           run_reg, run_next;
    logic                           mode_reg, mode_next;
    logic signed [lsrb_pkg::CW-1:0] dx, dy, ang;
    logic                           pos;

    // Shift, pick direction, add
    always_comb
    begin
        dx  = y_reg >>> step_reg;
        dy  = x_reg >>> step_reg;
        ang = lsrb_pkg::CW'(lsrb_pkg::atan_q16(step_reg));
        pos = mode_reg ? (y_reg >= 0) : (z_reg >= 0);
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        step_next = step_reg; run_next = run_reg; mode_next = mode_reg;
        if (load)
        begin
            x_next = x_in; y_next = y_in; z_next = z_in;
            step_next = '0; run_next = 1'b1; mode_next = vector_mode;
        end
        else if (run_reg)
        begin
            if (pos)
            begin
                // rotate clockwise in vector mode, counter-clockwise in rotate mode
                if (mode_reg)
                begin
                    x_next = x_reg + dx; y_next = y_reg - dy; z_next = z_reg + ang;
                end
                else
                begin
                    x_next = x_reg - dx; y_next = y_reg + dy; z_next = z_reg - ang;
                end
            end
            else
            begin
                if (mode_reg)
                begin
                    x_next = x_reg - dx; y_next = y_reg + dy; z_next = z_reg - ang;
                end
                else
                begin
                    x_next = x_reg + dx; y_next = y_reg - dy; z_next = z_reg + ang;
                end
            end
            step_next = step_reg + 1'b1;
            if (step_reg == lsrb_pkg::STEP_W'(lsrb_pkg::CORDIC_STEPS - 1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = run_reg && (step_reg == lsrb_pkg::STEP_W'(lsrb_pkg::CORDIC_STEPS - 1));
    assign x_out = x_next;
    assign z_out = z_next;
endmodule

>>> src/lidar_scan_reproject_bins.sv
// Top level: request sequencer, gain multiplier, bin store and register port.
//
//  channel  | signals                                   | direction
//  request  | start, busy, req_in                       | in/out
//  result   | res_valid, res_out                        | out
//  config   | psel penable pwrite paddr pwdata prdata   | in/out
//
// A full sample runs two 16-step passes of the shared CORDIC step unit, one gain
// multiply after each, and a write, and holds busy until done. A sample dropped
// by the horizontal check ends after the first multiply, by the bearing check
// after the second pass. A read's result shows as busy falls. Clear, ignored
// requests and samples dropped on entry do not hold busy. Reset sets config
// registers to defaults and clears written flags and the sequencer; bin data is
// undefined until written. The receiver cannot stall: a result shows for one cycle.
module lidar_scan_reproject_bins (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lsrb_pkg::req_word_t   req_in,
    output logic                  res_valid,
    output lsrb_pkg::res_word_t   res_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_HMUL = 3'd2;
    localparam logic [2:0] S_VEC  = 3'd3;
    localparam logic [2:0] S_RMUL = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    localparam int CW = lsrb_pkg::CW;

    logic [2:0]        state_reg, state_next;
    lsrb_pkg::cfg_t    cfg_reg;
    logic [lsrb_pkg::NUM_BINS-1:0] written_reg;
    logic [15:0]       bin_mem [lsrb_pkg::NUM_BINS];
    logic              mirror_q_reg;
    logic signed [CW-1:0] prod_in_reg;
    logic [6:0]        bin_reg;
    logic [15:0]       range_reg;
    logic              res_valid_reg;
    logic [6:0]        rd_sel_reg;
    logic [15:0]       rd_data_reg;
    logic              rd_hit_reg;
    logic              rd_pend_reg;

    logic              accept, wr_en;
    logic              cor_load, cor_vec, cor_done;
    logic signed [CW-1:0] cx, cy, cz, cx_out, cz_out;
    logic [8:0]        angle;
    logic [6:0]        count;
    logic [61:0]       prod;
    logic [CW-1:0]     gain_out;
    logic [CW-1:0]     off_q10;
    logic [CW-1:0]     rnd;
    logic [23:0]       bin_deg;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || rd_pend_reg;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Config register writes and reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_offset_mm <= '0;
            cfg_reg.detect_range_mm  <= 14'd6000;
            cfg_reg.min_dist_mm      <= '0;
            cfg_reg.angle_count      <= 7'd90;
            cfg_reg.mirror_mode      <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                lsrb_pkg::REG_OFFSET: cfg_reg.center_offset_mm <= pwdata[13:0];
                lsrb_pkg::REG_DETECT: cfg_reg.detect_range_mm  <= pwdata[13:0];
                lsrb_pkg::REG_MIN:    cfg_reg.min_dist_mm      <= pwdata[13:0];
                lsrb_pkg::REG_COUNT:  cfg_reg.angle_count      <= pwdata[6:0];
                lsrb_pkg::REG_MIRROR: cfg_reg.mirror_mode      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            lsrb_pkg::REG_OFFSET: prdata = {18'd0, cfg_reg.center_offset_mm};
            lsrb_pkg::REG_DETECT: prdata = {18'd0, cfg_reg.detect_range_mm};
            lsrb_pkg::REG_MIN:    prdata = {18'd0, cfg_reg.min_dist_mm};
            lsrb_pkg::REG_COUNT:  prdata = {25'd0, cfg_reg.angle_count};
            lsrb_pkg::REG_MIRROR: prdata = {31'd0, cfg_reg.mirror_mode};
            default:              prdata = '0;
        endcase
    end

    // Sample pre-checks
    assign count = (cfg_reg.angle_count > lsrb_pkg::MAX_BEAM) ? lsrb_pkg::MAX_BEAM
                                                              : cfg_reg.angle_count;
    assign angle = cfg_reg.mirror_mode ? (9'd359 - req_in.node_index) : req_in.node_index;
    assign off_q10 = CW'({cfg_reg.center_offset_mm, 10'd0});

    // Gain removal, one multiply per pass; CORDIC outputs stay below 2^27
    assign prod     = 62'(prod_in_reg[31:0]) * 62'(lsrb_pkg::INV_GAIN_Q30);
    assign gain_out = prod_in_reg <= 0 ? '0 : CW'(prod >> 30);
    assign rnd      = (gain_out + CW'(512)) >> 10;
    assign bin_deg  = cz_out[CW-1] ? 24'd0 : cz_out[39:16];

    // Sequencer control
    always_comb
    begin
        state_next = state_reg;
        cor_load = 1'b0;
        cor_vec  = 1'b0;
        cx = '0; cy = '0; cz = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_in.req_type == lsrb_pkg::REQ_SAMPLE
                    && req_in.node_index < 9'(lsrb_pkg::NUM_NODES)
                    && req_in.raw_distance != 16'd0
                    && angle < 9'(count))
                begin
                    cor_load = 1'b1;
                    cx = CW'({req_in.raw_distance, 8'd0});
                    cz = CW'({angle, 16'd0});
                    state_next = S_ROT;
                end
            end
            S_ROT:   if (cor_done) state_next = S_HMUL;
            S_HMUL:
            begin
                if (gain_out >= CW'({cfg_reg.detect_range_mm, 10'd0})
                    || gain_out < CW'({cfg_reg.min_dist_mm, 10'd0}))
                    state_next = S_IDLE;
                else if (gain_out == '0 && off_q10 == '0)
                    state_next = S_WRITE;
                else
                begin
                    cor_load = 1'b1;
                    cor_vec  = 1'b1;
                    cx = mirror_q_reg ? off_q10 : gain_out;
                    cy = mirror_q_reg ? gain_out : off_q10;
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                if (cor_done)
                    state_next = (bin_deg >= 24'(lsrb_pkg::NUM_BINS)) ? S_IDLE : S_RMUL;
            end
            S_RMUL:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    lsrb_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (cor_load),
        .vector_mode (cor_vec),
        .x_in        (cx),
        .y_in        (cy),
        .z_in        (cz),
        .done        (cor_done),
        .x_out       (cx_out),
        .z_out       (cz_out)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            written_reg   <= '0;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= rd_pend_reg;
            rd_pend_reg   <= accept && req_in.req_type == lsrb_pkg::REQ_READ;
            if (accept && req_in.req_type == lsrb_pkg::REQ_CLEAR)
                written_reg <= '0;
            else if (state_reg == S_WRITE)
                written_reg[bin_reg] <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mirror_q_reg <= cfg_reg.mirror_mode;
            rd_sel_reg   <= req_in.bin_select;
            rd_hit_reg   <= req_in.bin_select < 7'(lsrb_pkg::NUM_BINS)
                            && written_reg[req_in.bin_select];
        end
        if ((state_reg == S_ROT || state_reg == S_VEC) && cor_done)
            prod_in_reg <= cx_out;
        if (state_reg == S_VEC && cor_done)
            bin_reg <= bin_deg[6:0];
        if (state_reg == S_HMUL)
        begin
            range_reg <= '0;
            bin_reg   <= '0;
        end
        if (state_reg == S_RMUL)
            range_reg <= (rnd > CW'(65535)) ? 16'hFFFF : rnd[15:0];
    end

    // Bin store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            bin_mem[bin_reg] <= range_reg;
        if (rd_pend_reg == 1'b0 && accept)
            rd_data_reg <= bin_mem[req_in.bin_select < 7'(lsrb_pkg::NUM_BINS)
                                   ? req_in.bin_select : 7'd0];
    end

    always_ff @(posedge clk)
    begin
        res_out.bin_number   <= rd_sel_reg;
        res_out.bin_range_mm <= rd_hit_reg ? rd_data_reg : lsrb_pkg::UNWRITTEN_MM;
    end

    assign res_valid = res_valid_reg;
endmodule

>>> dv/lidar_scan_reproject_bins_tb.sv
// Testbench for the lidar bin re-projector: directed table, random requests, bin predictor.
module lidar_scan_reproject_bins_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 80;

    // typed-in expected result; free when the row is checked by the predictor only
    typedef struct {
        lsrb_pkg::req_word_t  req;
        logic                 fixed;
        lsrb_pkg::res_word_t  res;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    lsrb_pkg::req_word_t req_in = '0;
    logic        res_valid;
    lsrb_pkg::res_word_t res_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [13:0] cfg_offset;
    logic [13:0] cfg_detect;
    logic [13:0] cfg_min;
    logic [6:0]  cfg_count;
    logic        cfg_mirror;
    logic [15:0] bin_range_q [lsrb_pkg::NUM_BINS];
    logic        bin_valid_q [lsrb_pkg::NUM_BINS];

    lsrb_pkg::res_word_t expected_reads [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          sender_idle_pct = 0;

    table_row_t  directed [$];

    lidar_scan_reproject_bins u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req_in(req_in),
        .res_valid(res_valid), .res_out(res_out), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // arithmetic shift right, rounding toward minus infinity
    function automatic longint shift_down(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic longint strip_gain(longint v);
        if (v <= 0)
            return 0;
        return (v * 64'd652032874) >>> 30;
    endfunction

    // project one sample onto the bin store
    function automatic void project_sample(logic [8:0] node, logic [15:0] raw);
        int      beam;
        int      lim;
        longint  x, y, z, dx, dy, h, vx, vy, acc, rng;
        int      bin;
        lim = (cfg_count > 90) ? 90 : cfg_count;
        if (node >= lsrb_pkg::NUM_NODES || raw == 0)
            return;
        beam = cfg_mirror ? 359 - node : node;
        if (beam >= lim)
            return;
        x = longint'(raw) << 8;
        y = 0;
        z = longint'(beam) * 65536;
        for (int i = 0; i < lsrb_pkg::CORDIC_STEPS; i++)
        begin
            dx = shift_down(y, i);
            dy = shift_down(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        h = strip_gain(x);
        if (h >= (longint'(cfg_detect) << 10) || h < (longint'(cfg_min) << 10))
            return;
        vx = cfg_mirror ? longint'(cfg_offset) << 10 : h;
        vy = cfg_mirror ? h : longint'(cfg_offset) << 10;
        bin = 0;
        rng = 0;
        if (vx != 0 || vy != 0)
        begin
            acc = 0;
            for (int i = 0; i < lsrb_pkg::CORDIC_STEPS; i++)
            begin
                dx = shift_down(vy, i);
                dy = shift_down(vx, i);
                if (vy >= 0)
                begin
                    vx += dx; vy -= dy; acc += atan_step(i);
                end
                else
                begin
                    vx -= dx; vy += dy; acc -= atan_step(i);
                end
            end
            bin = (acc < 0) ? 0 : int'(acc >>> 16);
            rng = (strip_gain(vx) + 512) >>> 10;
            if (rng > 65535)
                rng = 65535;
        end
        if (bin >= lsrb_pkg::NUM_BINS)
            return;
        bin_range_q[bin] = rng[15:0];
        bin_valid_q[bin] = 1'b1;
    endfunction

    // advance the predictor by one accepted request
    function automatic void predict_request(lsrb_pkg::req_word_t r);
        lsrb_pkg::res_word_t e;
        case (r.req_type)
            lsrb_pkg::REQ_CLEAR:
                for (int i = 0; i < lsrb_pkg::NUM_BINS; i++)
                    bin_valid_q[i] = 1'b0;
            lsrb_pkg::REQ_SAMPLE:
                project_sample(r.node_index, r.raw_distance);
            lsrb_pkg::REQ_READ:
            begin
                e.bin_number   = r.bin_select;
                e.bin_range_mm = lsrb_pkg::UNWRITTEN_MM;
                if (r.bin_select < lsrb_pkg::NUM_BINS && bin_valid_q[r.bin_select])
                    e.bin_range_mm = bin_range_q[r.bin_select];
                expected_reads.push_back(e);
            end
            default: ;
        endcase
    endfunction

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("unexpected result word: bin_number %0d bin_range_mm %0d",
                       res_out.bin_number, res_out.bin_range_mm);
                fail_count++;
            end
            else
            begin
                if (res_out.bin_number !== expected_reads[0].bin_number)
                begin
                    $error("bin_number: expected %0d, actual %0d",
                           expected_reads[0].bin_number, res_out.bin_number);
                    fail_count++;
                end
                if (res_out.bin_range_mm !== expected_reads[0].bin_range_mm)
                begin
                    $error("bin_range_mm: expected %0d, actual %0d",
                           expected_reads[0].bin_range_mm, res_out.bin_range_mm);
                    fail_count++;
                end
                void'(expected_reads.pop_front());
            end
        end
    end

    // watchdog: count cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lsrb_pkg::REG_OFFSET: cfg_offset = value[13:0];
            lsrb_pkg::REG_DETECT: cfg_detect = value[13:0];
            lsrb_pkg::REG_MIN:    cfg_min    = value[13:0];
            lsrb_pkg::REG_COUNT:  cfg_count  = value[6:0];
            lsrb_pkg::REG_MIRROR: cfg_mirror = value[0];
            default: ;
        endcase
    endtask

    // drop start, hold until every read has returned, then let the block settle
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // drive one request word and hold it until accepted; start stays high so
    // the next word can follow at once
    task automatic send_request(lsrb_pkg::req_word_t r);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start  <= 1'b1;
        req_in <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(r);
    endtask

    function automatic lsrb_pkg::req_word_t make_req(logic [1:0] t, int node, int raw,
                                                     int sel);
        lsrb_pkg::req_word_t r;
        r.req_type     = t;
        r.node_index   = node[8:0];
        r.raw_distance = raw[15:0];
        r.bin_select   = sel[6:0];
        return r;
    endfunction

    function automatic void add_row(lsrb_pkg::req_word_t r, logic fixed, int bin, int rng);
        table_row_t row;
        row.req   = r;
        row.fixed = fixed;
        row.res.bin_number   = bin[6:0];
        row.res.bin_range_mm = rng[15:0];
        directed.push_back(row);
    endfunction

    // random request: mostly samples with a read now and then, rare clears
    function automatic lsrb_pkg::req_word_t random_req();
        int p;
        int sel;
        lsrb_pkg::req_word_t r;
        p = $urandom_range(99);
        r = lsrb_pkg::req_word_t'(34'({$urandom, $urandom}));
        if (p < 60)
        begin
            r.req_type = lsrb_pkg::REQ_SAMPLE;
            if ($urandom_range(9) < 8)
                r.node_index = 9'(cfg_mirror ? 359 - $urandom_range(89)
                                             : $urandom_range(89));
            if ($urandom_range(9) < 8)
                r.raw_distance = 16'($urandom_range(30000, 1));
        end
        else if (p < 92)
        begin
            r.req_type = lsrb_pkg::REQ_READ;
            sel = (p < 90) ? $urandom_range(lsrb_pkg::NUM_BINS - 1) : $urandom_range(127);
            r.bin_select = sel[6:0];
        end
        else if (p < 96)
            r.req_type = lsrb_pkg::REQ_CLEAR;
        else
            r.req_type = lsrb_pkg::REQ_RSVD;
        return r;
    endfunction

    initial
    begin
        int phase;
        int cfg_sets [5][5];
        lsrb_pkg::req_word_t r;
        cfg_offset = 14'd0;
        cfg_detect = 14'd6000;
        cfg_min    = 14'd0;
        cfg_count  = 7'd90;
        cfg_mirror = 1'b0;
        for (int i = 0; i < lsrb_pkg::NUM_BINS; i++)
        begin
            bin_range_q[i] = '0;
            bin_valid_q[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows: reads after reset, extremes, ignored cases
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 0), 1'b1, 0, 6000);
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 127), 1'b1, 127, 6000);
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 90), 1'b1, 90, 6000);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 511, 65535, 127), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 360, 4000, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_RSVD, 0, 4000, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 89), 1'b1, 89, 6000);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 0, 4000, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 89, 65535, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 45, 20000, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 0, 1, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 0, 23999, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_SAMPLE, 90, 4000, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_CLEAR, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_req(lsrb_pkg::REQ_READ, 0, 0, 0), 1'b1, 0, 6000);

        foreach (directed[k])
        begin
            send_request(directed[k].req);
            if (directed[k].fixed && expected_reads.size() != 0)
                expected_reads[$] = directed[k].res;
        end

        // zero offset with the smallest distance; offset of full scale
        drain();
        write_reg(lsrb_pkg::REG_OFFSET, 32'd0);
        write_reg(lsrb_pkg::REG_MIN, 32'd0);
        send_request(make_req(lsrb_pkg::REQ_SAMPLE, 0, 1, 0));
        send_request(make_req(lsrb_pkg::REQ_READ, 0, 0, 0));
        drain();
        write_reg(lsrb_pkg::REG_OFFSET, 32'h3FFF);
        send_request(make_req(lsrb_pkg::REQ_SAMPLE, 10, 8000, 0));
        send_request(make_req(lsrb_pkg::REQ_READ, 0, 0, 89));
        drain();

        // walk register settings with the sender idling in phases 1 and 3
        cfg_sets = '{'{0, 6000, 0, 90, 0}, '{500, 16383, 0, 127, 0},
                     '{2000, 8000, 300, 60, 1}, '{16383, 16383, 16383, 0, 1},
                     '{1200, 5000, 100, 90, 1}};
        for (phase = 0; phase < 5; phase++)
        begin
            drain();
            write_reg(lsrb_pkg::REG_OFFSET, cfg_sets[phase][0]);
            write_reg(lsrb_pkg::REG_DETECT, cfg_sets[phase][1]);
            write_reg(lsrb_pkg::REG_MIN,    cfg_sets[phase][2]);
            write_reg(lsrb_pkg::REG_COUNT,  cfg_sets[phase][3]);
            write_reg(lsrb_pkg::REG_MIRROR, cfg_sets[phase][4]);
            sender_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 10 : 0;
            for (int n = 0; n < 220; n++)
            begin
                r = random_req();
                send_request(r);
                if (n == 100)
                    drain();
            end
        end
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> lidar_scan_reproject_bins.f
src/lsrb_pkg.sv
src/lsrb_cordic.sv
src/lidar_scan_reproject_bins.sv
dv/lidar_scan_reproject_bins_tb.sv
